/* design/a2ab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// a2ab_pkg
// Shared types and constants for the avcC / length-prefixed to Annex-B
// NAL converter.
// ----------------------------------------------------------------------------
package a2ab_pkg;

  localparam int PARAM_STORE_BYTES = 192;
  localparam int IDX_W  = $clog2(PARAM_STORE_BYTES);
  localparam int FILL_W = $clog2(PARAM_STORE_BYTES + 5);

  localparam logic [FILL_W-1:0] FILL_CAP   = FILL_W'(PARAM_STORE_BYTES);
  localparam logic [FILL_W-1:0] FILL_OVF   = FILL_W'(PARAM_STORE_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_SC_OK = FILL_W'(PARAM_STORE_BYTES - 4);

  localparam logic OP_CONFIG = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_TRUNC     = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [2:0] STAT_MALFORMED = 3'd4;

  localparam logic [2:0] HDR_COUNT_IDX = 3'd5;
  localparam logic [2:0] PKT_FULL      = 3'd5;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [7:0] MAX_SET_COUNT = 8'd31;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_SPS_LEN,
    PH_SPS_DATA,
    PH_PPS_CNT,
    PH_PPS_LEN,
    PH_PPS_DATA,
    PH_DONE
  } cfg_phase_t;

  typedef enum logic {
    CS_IDLE,
    CS_EMIT
  } conv_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [2:0]  out_bytes;
    logic        run_last;
    logic        packet_end;
    logic [2:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage
`default_nettype wire

/* design/a2ab_cfg_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// a2ab_cfg_parser
// Parses avcC record bytes, tracks the parameter-set fill level and issues
// writes of set payloads and start codes into the parameter store.
// ----------------------------------------------------------------------------
module a2ab_cfg_parser
  import a2ab_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        byte_in,
  input  logic              last,
  output logic [FILL_W-1:0] fill,
  output logic              busy,
  output store_wr_t         wr,
  output logic [2:0]        close_status
);

  cfg_phase_t        phase, phase_next;
  logic [2:0]        idx, idx_next;
  logic [4:0]        sets_left, sets_left_next;
  logic [15:0]       set_left, set_left_next;
  logic              cerr, cerr_next;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] sc_base;
  logic [1:0]        sc_k;
  logic [FILL_W-1:0] sc_addr;
  logic              sc_go;
  logic              byte_we;
  logic              fin;
  logic              sps;
  logic [15:0]       set_len;
  logic [4:0]        sets_dec;

  always_comb begin
    phase_next     = phase;
    idx_next       = idx;
    sets_left_next = sets_left;
    set_left_next  = set_left;
    cerr_next      = cerr;
    fill_next      = fill;
    sc_go          = 1'b0;
    byte_we        = 1'b0;
    fin            = 1'b0;
    set_len        = {set_left[7:0], byte_in};
    sets_dec       = sets_left - 5'd1;
    sps            = (phase == PH_SPS_LEN) || (phase == PH_SPS_DATA);
    close_status   = STAT_OK;
    if (take) begin
      unique case (phase)
        PH_HDR: begin
          if (idx == 3'd0) begin
            fill_next = '0;
            cerr_next = 1'b0;
          end
          if (idx >= HDR_COUNT_IDX) begin
            sets_left_next = byte_in[4:0];
            idx_next       = 3'd0;
            phase_next     = (byte_in[4:0] != 5'd0) ? PH_SPS_LEN : PH_PPS_CNT;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
        PH_SPS_LEN, PH_PPS_LEN: begin
          if (idx == 3'd0) begin
            set_left_next = {8'h00, byte_in};
            idx_next      = 3'd1;
          end else begin
            set_left_next = set_len;
            idx_next      = 3'd0;
            sc_go         = 1'b1;
            fill_next     = (fill <= FILL_SC_OK) ? fill + FILL_W'(4) : FILL_OVF;
            if (set_len == 16'd0) begin
              fin = 1'b1;
            end else begin
              phase_next = (phase == PH_SPS_LEN) ? PH_SPS_DATA : PH_PPS_DATA;
            end
          end
        end
        PH_SPS_DATA, PH_PPS_DATA: begin
          byte_we       = (fill < FILL_CAP);
          fill_next     = byte_we ? fill + FILL_W'(1) : FILL_OVF;
          set_left_next = set_left - 16'd1;
          if (set_left == 16'd1) begin
            fin = 1'b1;
          end
        end
        PH_PPS_CNT: begin
          idx_next = 3'd0;
          if (byte_in > MAX_SET_COUNT) begin
            cerr_next  = 1'b1;
            phase_next = PH_DONE;
          end else begin
            sets_left_next = byte_in[4:0];
            phase_next     = (byte_in != 8'd0) ? PH_PPS_LEN : PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (fin) begin
        sets_left_next = sets_dec;
        if (sets_dec == 5'd0) begin
          phase_next = sps ? PH_PPS_CNT : PH_DONE;
        end else begin
          phase_next = sps ? PH_SPS_LEN : PH_PPS_LEN;
        end
      end
      if (last) begin
        if (fill_next > FILL_CAP) begin
          close_status = STAT_OVERFLOW;
        end else if (cerr_next || (phase_next != PH_DONE)) begin
          close_status = STAT_MALFORMED;
        end
        phase_next     = PH_HDR;
        idx_next       = 3'd0;
        sets_left_next = 5'd0;
        set_left_next  = 16'd0;
      end
    end
  end

  assign sc_addr = sc_base + FILL_W'(sc_k);

  always_comb begin
    if (busy) begin
      wr.we   = (sc_addr < FILL_CAP);
      wr.addr = sc_addr[IDX_W-1:0];
      wr.data = (sc_k == 2'd3) ? 8'h01 : 8'h00;
    end else begin
      wr.we   = byte_we;
      wr.addr = fill[IDX_W-1:0];
      wr.data = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      idx       <= 3'd0;
      sets_left <= 5'd0;
      set_left  <= 16'd0;
      cerr      <= 1'b0;
      fill      <= '0;
      busy      <= 1'b0;
      sc_k      <= 2'd0;
      sc_base   <= '0;
    end else begin
      phase     <= phase_next;
      idx       <= idx_next;
      sets_left <= sets_left_next;
      set_left  <= set_left_next;
      cerr      <= cerr_next;
      fill      <= fill_next;
      if (sc_go) begin
        busy    <= 1'b1;
        sc_base <= fill;
        sc_k    <= 2'd0;
      end else if (busy) begin
        sc_k <= sc_k + 2'd1;
        if (sc_k == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/avcc_to_annexb_nal_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avcc_to_annexb_nal_converter
// Converts avcC configuration records and length-prefixed H.264 packets
// into an Annex-B stream packed in 32-bit beats.
// ----------------------------------------------------------------------------
// Configuration bytes, NAL length bytes and ordinary NAL bytes are taken
// directly. The second byte of a parameter-set length holds the input while
// the start code is written into the parameter store. A NAL header byte
// holds the input while the converter emits the stored parameter sets (only
// for IDR, and only when the store has not overflowed), read from the store
// one byte a cycle unless the output stalls, then the start code and the
// header byte. A byte is taken only when the output register is empty or
// being drained, and output stalls hold the emit sequence.
module avcc_to_annexb_nal_converter
  import a2ab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  conv_state_t state, state_next;

  logic              accept, cfg_take, pkt_take;
  logic              out_free;
  logic [FILL_W-1:0] param_fill;
  logic              cfg_busy;
  store_wr_t         store_wr;
  logic [2:0]        cfg_status;

  logic [7:0]        mem [PARAM_STORE_BYTES];
  logic [7:0]        rd_data;
  logic [IDX_W-1:0]  rd_addr;

  logic [1:0]        prefix_pos, prefix_pos_next;
  logic [31:0]       length_acc, length_acc_next;
  logic [31:0]       nal_left, nal_left_next;
  logic              header_next, header_next_q;
  logic [2:0]        pkt_count, pkt_count_next;
  logic [31:0]       acc_shift;
  logic              go_emit;
  logic              single_v;
  logic [31:0]       single_word;
  logic [2:0]        single_bytes;
  logic [2:0]        pkt_status;

  logic [FILL_W-1:0] em_ps_len;
  logic [7:0]        em_byte;
  logic              em_last;
  logic [2:0]        em_status;
  logic [FILL_W-1:0] pos, pos_next;
  logic [FILL_W-1:0] rel;
  logic              in_ps;
  logic              em_final;
  logic [7:0]        cur;
  logic              push;
  logic              advance;
  logic [23:0]       asm_data, asm_data_next;
  logic [1:0]        asm_cnt, asm_cnt_next;
  logic [31:0]       push_word;

  logic              load;
  out_beat_t         load_beat;

  a2ab_cfg_parser u_cfg (
    .clk          (clk),
    .rst          (rst),
    .take         (cfg_take),
    .byte_in      (in_beat.byte_in),
    .last         (in_beat.last),
    .fill         (param_fill),
    .busy         (cfg_busy),
    .wr           (store_wr),
    .close_status (cfg_status)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == CS_IDLE) && !cfg_busy && out_free;
  assign accept   = in_valid && in_ready;
  assign cfg_take = accept && (in_beat.op == OP_CONFIG);
  assign pkt_take = accept && (in_beat.op == OP_PACKET);

  // packet parse
  always_comb begin
    prefix_pos_next = prefix_pos;
    length_acc_next = length_acc;
    nal_left_next   = nal_left;
    header_next     = header_next_q;
    pkt_count_next  = (pkt_count < PKT_FULL) ? pkt_count + 3'd1 : pkt_count;
    acc_shift       = {length_acc[23:0], in_beat.byte_in};
    go_emit         = 1'b0;
    single_v        = 1'b0;
    single_word     = 32'h0000_0000;
    single_bytes    = 3'd0;
    pkt_status      = STAT_OK;
    if (nal_left == 32'd0) begin
      prefix_pos_next = prefix_pos + 2'd1;
      if (prefix_pos == 2'd3) begin
        nal_left_next   = acc_shift;
        length_acc_next = 32'd0;
        if (acc_shift == 32'd0) begin
          if (!(in_beat.last && (pkt_count_next < PKT_FULL))) begin
            single_v     = 1'b1;
            single_word  = 32'h0000_0001;
            single_bytes = 3'd4;
          end
        end else begin
          header_next = 1'b1;
        end
      end else begin
        length_acc_next = acc_shift;
      end
    end else begin
      nal_left_next = nal_left - 32'd1;
      if (header_next_q) begin
        header_next = 1'b0;
        go_emit     = 1'b1;
      end else begin
        single_v     = 1'b1;
        single_word  = {in_beat.byte_in, 24'h00_0000};
        single_bytes = 3'd1;
      end
    end
    if (in_beat.last) begin
      if (pkt_count_next < PKT_FULL) begin
        pkt_status = STAT_SHORT;
      end else if ((nal_left_next != 32'd0) || (prefix_pos_next != 2'd0)) begin
        pkt_status = STAT_TRUNC;
      end
      prefix_pos_next = 2'd0;
      length_acc_next = 32'd0;
      nal_left_next   = 32'd0;
      header_next     = 1'b0;
      pkt_count_next  = 3'd0;
    end
  end

  // emit sequence: stored sets, start code, header byte
  assign in_ps    = (pos < em_ps_len);
  assign rel      = pos - em_ps_len;
  assign em_final = !in_ps && (rel == FILL_W'(4));

  always_comb begin
    if (in_ps) begin
      cur = rd_data;
    end else if (rel == FILL_W'(4)) begin
      cur = em_byte;
    end else if (rel == FILL_W'(3)) begin
      cur = 8'h01;
    end else begin
      cur = 8'h00;
    end
  end

  always_comb begin
    unique case (asm_cnt)
      2'd0: push_word = {cur, 24'h00_0000};
      2'd1: push_word = {asm_data[23:16], cur, 16'h0000};
      2'd2: push_word = {asm_data[23:8], cur, 8'h00};
      default: push_word = {asm_data, cur};
    endcase
  end

  assign push    = (state == CS_EMIT) && ((asm_cnt == 2'd3) || em_final);
  assign advance = !push || out_free;

  always_comb begin
    asm_data_next = asm_data;
    asm_cnt_next  = asm_cnt;
    if ((state == CS_EMIT) && advance) begin
      if (push) begin
        asm_cnt_next = 2'd0;
      end else begin
        asm_data_next = push_word[31:8];
        asm_cnt_next  = asm_cnt + 2'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (pkt_take && go_emit) begin
          state_next = CS_EMIT;
        end
      end
      CS_EMIT: begin
        if (em_final && advance) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // outputs of the sequence
  always_comb begin
    load      = 1'b0;
    load_beat = '0;
    pos_next  = '0;
    unique case (state)
      CS_IDLE: begin
        if (cfg_take && in_beat.last) begin
          load                 = 1'b1;
          load_beat.run_last   = 1'b1;
          load_beat.packet_end = 1'b1;
          load_beat.status     = cfg_status;
        end else if (pkt_take && !go_emit && (single_v || in_beat.last)) begin
          load                 = 1'b1;
          load_beat.out_data   = single_word;
          load_beat.out_bytes  = single_bytes;
          load_beat.run_last   = 1'b1;
          load_beat.packet_end = in_beat.last;
          load_beat.status     = in_beat.last ? pkt_status : STAT_OK;
        end
      end
      CS_EMIT: begin
        if (advance) begin
          pos_next = em_final ? '0 : pos + FILL_W'(1);
        end else begin
          pos_next = pos;
        end
        if (push && out_free) begin
          load                 = 1'b1;
          load_beat.out_data   = push_word;
          load_beat.out_bytes  = {1'b0, asm_cnt} + 3'd1;
          load_beat.run_last   = em_final;
          load_beat.packet_end = em_final && em_last;
          load_beat.status     = (em_final && em_last) ? em_status : STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = pos_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      prefix_pos    <= 2'd0;
      length_acc    <= 32'd0;
      nal_left      <= 32'd0;
      header_next_q <= 1'b0;
      pkt_count     <= 3'd0;
      pos           <= '0;
      asm_cnt       <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      asm_cnt <= asm_cnt_next;
      if (pkt_take) begin
        prefix_pos    <= prefix_pos_next;
        length_acc    <= length_acc_next;
        nal_left      <= nal_left_next;
        header_next_q <= header_next;
        pkt_count     <= pkt_count_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    asm_data <= asm_data_next;
    if (load) begin
      out_beat <= load_beat;
    end
    if (pkt_take && go_emit) begin
      em_ps_len <= ((in_beat.byte_in[4:0] == NAL_IDR) && (param_fill <= FILL_CAP))
                   ? param_fill : '0;
      em_byte   <= in_beat.byte_in;
      em_last   <= in_beat.last;
      em_status <= in_beat.last ? pkt_status : STAT_OK;
    end
  end

endmodule
`default_nettype wire

/* verif/tb_avcc_to_annexb_nal_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_avcc_to_annexb_nal_converter
// Self-checking bench for the avcC / length-prefixed to Annex-B converter.
// A short scripted stream (malformed and short inputs, a small record, a cut
// IDR packet) runs first, then a long record that exactly fills and then
// overflows the parameter store, then random records, packets and stray bytes.
// Every accepted byte goes through a local model of the converter, and each
// output beat is compared field by field with the oldest predicted beat, under
// random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_avcc_to_annexb_nal_converter;
  import a2ab_pkg::*;

  localparam int RANDOM_BYTES = 60;
  localparam int LIMIT        = 1_000_000;
  localparam int SETTLE       = 2 * PARAM_STORE_BYTES + 64;
  localparam int SCRIPT_LEN   = 25;

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum {REC_CLEAN, REC_CUT, REC_TRAILING, REC_BAD_COUNT} rec_fault_t;
  typedef enum {PKT_CLEAN, PKT_SHORT, PKT_CUT, PKT_HUGE} pkt_fault_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
    logic       pin;
    logic [2:0] status;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // record cut after its first byte
    '{OP_CONFIG, 8'h00, 1'b1, 1'b1, STAT_MALFORMED},
    // four-byte packet holding a zero-length NAL
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h00, 1'b1, 1'b1, STAT_SHORT},
    // one SPS of two bytes, one PPS of one byte
    '{OP_CONFIG, 8'h01, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h64, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h1f, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'hff, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'he1, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h02, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h67, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h42, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h01, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h01, 1'b0, 1'b0, STAT_OK},
    '{OP_CONFIG, 8'h68, 1'b1, 1'b1, STAT_OK},
    // IDR NAL of three bytes, packet ends after two
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h00, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h03, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'h65, 1'b0, 1'b0, STAT_OK},
    '{OP_PACKET, 8'hff, 1'b1, 1'b0, STAT_OK}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  avcc_to_annexb_nal_converter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // converter model state
  logic [7:0]  set_store [PARAM_STORE_BYTES];
  int unsigned set_fill  = 0;
  cfg_phase_t  cfg_ph    = PH_HDR;
  logic [2:0]  cfg_idx   = '0;
  logic [4:0]  sets_left = '0;
  logic [15:0] set_left  = '0;
  logic        cfg_bad   = 1'b0;
  logic [1:0]  len_pos   = '0;
  logic [31:0] len_acc   = '0;
  logic [31:0] nal_left  = '0;
  logic        at_header = 1'b0;
  logic [2:0]  pkt_seen  = '0;
  logic [7:0]  annexb_bytes [$];

  out_beat_t   pending_words [$];
  logic [31:0] cycle_cnt = '0;
  int          mismatches   = 0;
  int          words_seen   = 0;
  int          cfg_fed      = 0;
  int          pkt_fed      = 0;
  int          idr_inserts  = 0;
  int          stall_left   = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic in_beat_t beat(logic op, logic [7:0] data, logic last);
    in_beat_t b;
    b.op      = op;
    b.byte_in = data;
    b.last    = last;
    return b;
  endfunction

  function automatic bit calm_phase();
    return cycle_cnt[11:10] == 2'b01;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase() || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void store_put(logic [7:0] b);
    if (set_fill < PARAM_STORE_BYTES) begin
      set_store[set_fill] = b;
      set_fill++;
    end else begin
      set_fill = PARAM_STORE_BYTES + 1;
    end
  endfunction

  function automatic void next_set();
    bit sps;
    sps = (cfg_ph == PH_SPS_LEN || cfg_ph == PH_SPS_DATA);
    sets_left = sets_left - 5'd1;
    if (sets_left == 0) cfg_ph = sps ? PH_PPS_CNT : PH_DONE;
    else cfg_ph = sps ? PH_SPS_LEN : PH_PPS_LEN;
  endfunction

  // Advance the model by one byte and return the beats it produces.
  function automatic void convert_byte(input in_beat_t b, output out_beat_t words [$]);
    logic [2:0]  st;
    int unsigned nw;
    int unsigned cnt;
    out_beat_t   w;
    st = STAT_OK;
    words = {};
    annexb_bytes.delete();
    if (b.op == OP_PACKET) begin
      if (pkt_seen < PKT_FULL) pkt_seen++;
      if (nal_left == 0) begin
        len_acc = {len_acc[23:0], b.byte_in};
        len_pos++;
        if (len_pos == 0) begin
          nal_left = len_acc;
          len_acc  = '0;
          if (nal_left == 0) begin
            if (!(b.last && pkt_seen < PKT_FULL))
              foreach (START_CODE[i]) annexb_bytes.push_back(START_CODE[i]);
          end else begin
            at_header = 1'b1;
          end
        end
      end else begin
        if (at_header) begin
          at_header = 1'b0;
          if (b.byte_in[4:0] == NAL_IDR && set_fill <= PARAM_STORE_BYTES) begin
            for (int i = 0; i < set_fill; i++) annexb_bytes.push_back(set_store[i]);
            if (set_fill != 0) idr_inserts++;
          end
          foreach (START_CODE[i]) annexb_bytes.push_back(START_CODE[i]);
        end
        annexb_bytes.push_back(b.byte_in);
        nal_left--;
      end
      if (b.last) begin
        if (pkt_seen < PKT_FULL) st = STAT_SHORT;
        else if (nal_left != 0 || len_pos != 0) st = STAT_TRUNC;
        len_pos   = '0;
        len_acc   = '0;
        nal_left  = '0;
        at_header = 1'b0;
        pkt_seen  = '0;
      end
    end else begin
      case (cfg_ph)
        PH_HDR: begin
          if (cfg_idx == 0) begin
            set_fill = 0;
            cfg_bad  = 1'b0;
          end
          if (cfg_idx >= HDR_COUNT_IDX) begin
            sets_left = b.byte_in[4:0];
            cfg_idx   = '0;
            cfg_ph    = (sets_left != 0) ? PH_SPS_LEN : PH_PPS_CNT;
          end else begin
            cfg_idx++;
          end
        end
        PH_SPS_LEN, PH_PPS_LEN: begin
          if (cfg_idx == 0) begin
            set_left = {8'h00, b.byte_in};
            cfg_idx  = 3'd1;
          end else begin
            set_left = {set_left[7:0], b.byte_in};
            cfg_idx  = '0;
            foreach (START_CODE[i]) store_put(START_CODE[i]);
            if (set_left == 0) next_set();
            else cfg_ph = (cfg_ph == PH_SPS_LEN) ? PH_SPS_DATA : PH_PPS_DATA;
          end
        end
        PH_SPS_DATA, PH_PPS_DATA: begin
          store_put(b.byte_in);
          set_left--;
          if (set_left == 0) next_set();
        end
        PH_PPS_CNT: begin
          cfg_idx = '0;
          if (b.byte_in > MAX_SET_COUNT) begin
            cfg_bad = 1'b1;
            cfg_ph  = PH_DONE;
          end else begin
            sets_left = b.byte_in[4:0];
            cfg_ph    = (b.byte_in != 0) ? PH_PPS_LEN : PH_DONE;
          end
        end
        default: ;
      endcase
      if (b.last) begin
        if (set_fill > PARAM_STORE_BYTES) st = STAT_OVERFLOW;
        else if (cfg_bad || cfg_ph != PH_DONE) st = STAT_MALFORMED;
        cfg_ph    = PH_HDR;
        cfg_idx   = '0;
        sets_left = '0;
        set_left  = '0;
      end
    end

    nw = (annexb_bytes.size() + 3) / 4;
    if (nw == 0 && b.last) nw = 1;
    for (int k = 0; k < nw; k++) begin
      w   = '0;
      cnt = 0;
      while (cnt < 4 && annexb_bytes.size() != 0) begin
        w.out_data[31 - 8 * cnt -: 8] = annexb_bytes.pop_front();
        cnt++;
      end
      w.out_bytes  = 3'(cnt);
      w.run_last   = (k == nw - 1);
      w.packet_end = w.run_last && b.last;
      w.status     = w.packet_end ? st : STAT_OK;
      words.push_back(w);
    end
  endfunction

  // Present one byte after a random gap; predict once it is taken.
  task automatic send(input in_beat_t b, input bit pin = 1'b0,
                      input logic [2:0] pin_status = STAT_OK);
    int        gap;
    out_beat_t words [$];
    out_beat_t fixed;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    convert_byte(b, words);
    if (b.op == OP_PACKET) pkt_fed++;
    else cfg_fed++;
    if (pin) begin
      fixed = '{out_data: '0, out_bytes: '0, run_last: 1'b1, packet_end: 1'b1,
                status: pin_status};
      pending_words.push_back(fixed);
    end else begin
      foreach (words[i]) pending_words.push_back(words[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic feed_record(input int sps_len [$], input int pps_len [$],
                             input rec_fault_t fault);
    logic [7:0] rec [$];
    repeat (5) rec.push_back(8'($urandom));
    rec.push_back({3'($urandom), 5'(sps_len.size())});
    foreach (sps_len[i]) begin
      rec.push_back(8'(sps_len[i] >> 8));
      rec.push_back(8'(sps_len[i]));
      repeat (sps_len[i]) rec.push_back(8'($urandom));
    end
    if (fault == REC_BAD_COUNT) begin
      rec.push_back(8'($urandom_range(32, 255)));
    end else begin
      rec.push_back(8'(pps_len.size()));
      foreach (pps_len[i]) begin
        rec.push_back(8'(pps_len[i] >> 8));
        rec.push_back(8'(pps_len[i]));
        repeat (pps_len[i]) rec.push_back(8'($urandom));
      end
    end
    if (fault == REC_TRAILING || fault == REC_BAD_COUNT)
      repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
    if (fault == REC_CUT && rec.size() > 1)
      rec = rec[0:$urandom_range(0, rec.size() - 2)];
    foreach (rec[i]) send(beat(OP_CONFIG, rec[i], i == rec.size() - 1));
  endtask

  task automatic feed_packet(input int nals, input int min_len, input int max_len,
                             input int idr_pct, input pkt_fault_t fault);
    logic [7:0]  pkt [$];
    logic [31:0] len;
    int          body;
    for (int n = 0; n < nals; n++) begin
      len = $urandom_range(min_len, max_len);
      if (fault == PKT_HUGE && n == nals - 1)
        len = {8'($urandom_range(1, 255)), 24'($urandom)};
      for (int s = 24; s >= 0; s -= 8) pkt.push_back(len[s +: 8]);
      if (len != 0) begin
        pkt.push_back(($urandom_range(0, 99) < idr_pct) ? {3'($urandom), NAL_IDR}
                                                          : 8'($urandom));
        body = (fault == PKT_HUGE && n == nals - 1) ? $urandom_range(0, 3) : len - 1;
        repeat (body) pkt.push_back(8'($urandom));
      end
    end
    if (fault == PKT_SHORT) begin
      pkt.delete();
      repeat ($urandom_range(1, 4))
        pkt.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
    end
    if (fault == PKT_CUT && pkt.size() > 1)
      pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
    foreach (pkt[i]) send(beat(OP_PACKET, pkt[i], i == pkt.size() - 1));
  endtask

  // fill the store exactly with empty sets, insert it into an IDR, then overflow it
  task automatic feed_store_edge();
    repeat (5) send(beat(OP_CONFIG, 8'($urandom), 1'b0));
    send(beat(OP_CONFIG, {3'($urandom), 5'd31}, 1'b0));
    repeat (62) send(beat(OP_CONFIG, 8'h00, 1'b0));
    send(beat(OP_CONFIG, 8'd18, 1'b0));
    repeat (34) send(beat(OP_CONFIG, 8'h00, 1'b0));
    feed_packet(1, 1, 3, 100, PKT_CLEAN);
    send(beat(OP_CONFIG, 8'h00, 1'b0));
    send(beat(OP_CONFIG, 8'h00, 1'b1));
    feed_packet(1, 2, 4, 100, PKT_CLEAN);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $error("timeout with %0d beats still pending", pending_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // output stalls: mostly ready, some short holds, a few long ones
  always @(posedge clk) begin : sink_ctl
    int roll;
    roll = $urandom_range(0, 99);
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (calm_phase()) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (roll < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : word_check
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("output beat %h with nothing pending", out_beat);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_data", want.out_data, out_beat.out_data);
        check_field("out_bytes", want.out_bytes, out_beat.out_bytes);
        check_field("run_last", want.run_last, out_beat.run_last);
        check_field("packet_end", want.packet_end, out_beat.packet_end);
        check_field("status", want.status, out_beat.status);
      end
    end
  end

  initial begin : stimulus
    int sps_q [$];
    int pps_q [$];
    int mark;
    int pick;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_beat  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i])
      send(beat(SCRIPT[i].op, SCRIPT[i].data, SCRIPT[i].last),
           SCRIPT[i].pin, SCRIPT[i].status);

    // hold input until the scripted stream has fully drained
    wait_drained();

    // full store carried by an IDR, then overflow and an IDR without sets
    feed_store_edge();

    mark = cfg_fed + pkt_fed;
    while (cfg_fed + pkt_fed < mark + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        sps_q.delete();
        pps_q.delete();
        repeat ($urandom_range(0, 2)) sps_q.push_back($urandom_range(0, 8));
        repeat ($urandom_range(0, 2)) pps_q.push_back($urandom_range(0, 4));
        feed_record(sps_q, pps_q,
                    ($urandom_range(0, 99) < 60) ? REC_CLEAN
                                                 : rec_fault_t'($urandom_range(1, 3)));
      end else if (pick < 88) begin
        pick = $urandom_range(0, 99);
        feed_packet($urandom_range(1, 3), 0, 6, 35,
                    (pick < 65) ? PKT_CLEAN : (pick < 77) ? PKT_SHORT :
                    (pick < 90) ? PKT_CUT : PKT_HUGE);
      end else begin
        repeat ($urandom_range(1, 4))
          send(beat(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0));
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Fed %0d config and %0d packet bytes, checked %0d output beats,",
             cfg_fed, pkt_fed, words_seen);
    $display("with %0d IDR headers carrying stored parameter sets.", idr_inserts);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
